[sv/rtu_frame_receive_checker_top_macros.svh]
// Assertion macros for the frame receive checker.
`ifndef RTU_FRAME_RECEIVE_CHECKER_TOP_MACROS_SVH
`define RTU_FRAME_RECEIVE_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RTUFRC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtufrc assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RTUFRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtufrc assertion failed");

`endif

[sv/rtufrc_pkg.sv]
// Shared types and constants for the frame receive checker.
package rtufrc_pkg;

   // beat function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_BYTE  = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;

   // error reason codes
   localparam logic [1:0] REASON_NONE  = 2'd0;
   localparam logic [1:0] REASON_LINE  = 2'd1;
   localparam logic [1:0] REASON_SHORT = 2'd2;
   localparam logic [1:0] REASON_CRC   = 2'd3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int FRAME_MAX_DEFAULT = 256;
   localparam int FRAME_MIN_DEFAULT = 4;

   typedef struct packed {
      logic       status;
      logic [1:0] error_reason;
      logic [7:0] slave_address;
      logic [7:0] pdu_length;
   } rsp_type;

endpackage

[sv/rtufrc_interfaces.sv]
// Request and response channel interfaces.
interface rtufrc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;
   logic       line_error;

   modport source (output valid, output func, output data_byte, output line_error,
                   input ready);
   modport sink   (input valid, input func, input data_byte, input line_error,
                   output ready);
endinterface

interface rtufrc_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [1:0] error_reason;
   logic [7:0] slave_address;
   logic [7:0] pdu_length;

   modport source (output valid, output status, output error_reason,
                   output slave_address, output pdu_length, input ready);
   modport sink   (input valid, input status, input error_reason,
                   input slave_address, input pdu_length, output ready);
endinterface

[sv/rtufrc_crc_fold.sv]
// CRC-16 (reflected 0xA001) update over one byte.
module rtufrc_crc_fold
   import rtufrc_pkg::*;
(
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data_byte};
      for (int i = 0; i < 8; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

[sv/rtu_frame_receive_checker_top.sv]
// Frame receive checker: counts bytes, runs the CRC and judges the frame at frame end.
// A frame-end beat gives its response beat in the next cycle.
// Throughput: one request beat per cycle unless a pending response stalls; the byte-wide CRC fold is combinational.
// A pending response blocks new requests only while the response side stalls.
// Reset (synchronous, active high) clears the count, error flag, address, sets the
// CRC to 0xFFFF and drops the response valid; no clearing pass is needed.
module rtu_frame_receive_checker_top
   import rtufrc_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEFAULT,
   parameter int FRAME_MIN = FRAME_MIN_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   rtufrc_req_if.sink   req_chan,
   rtufrc_rsp_if.source rsp_chan
);

   // count must hold FRAME_MAX itself
   localparam int CW = $clog2(FRAME_MAX + 1);

   // frame state
   logic [CW-1:0] count_ff, count_in;
   logic          error_flag_ff, error_flag_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    address_ff, address_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          req_fire;
   logic          rsp_fire;
   logic [15:0]   crc_folded;
   logic [CW+7:0] count_wide;
   logic [CW+7:0] len_wide;
   logic          count_full;
   logic          too_short;

   // accept while the output slot is empty or is being drained this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   rtufrc_crc_fold u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_chan.data_byte),
      .crc_next  (crc_folded)
   );

   assign count_wide = {8'h00, count_ff};
   assign len_wide   = count_wide - (CW + 8)'(3);
   assign count_full = (count_ff == CW'(FRAME_MAX));
   assign too_short  = (count_wide < (CW + 8)'(FRAME_MIN));

   // verdict on the state as it stands before the frame-end beat
   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = 1'b1;
      rsp_in.error_reason  = REASON_NONE;
      if (error_flag_ff) begin
         rsp_in.error_reason = REASON_LINE;
      end else if (too_short) begin
         rsp_in.error_reason = REASON_SHORT;
      end else if (crc_ff != 16'h0000) begin
         rsp_in.error_reason = REASON_CRC;
      end else begin
         rsp_in.status        = 1'b0;
         rsp_in.slave_address = address_ff;
         rsp_in.pdu_length    = len_wide[7:0];
      end
   end

   // state update per accepted beat; func 3 leaves everything alone
   always_comb begin
      count_in      = count_ff;
      error_flag_in = error_flag_ff;
      crc_in        = crc_ff;
      address_in    = address_ff;
      if (req_fire) begin
         case (req_chan.func)
            FUNC_START, FUNC_END: begin
               count_in      = '0;
               error_flag_in = 1'b0;
               crc_in        = CRC_INIT;
               address_in    = 8'h00;
            end
            FUNC_BYTE: begin
               // once flagged, bytes are dropped until the frame is cleared
               if (req_chan.line_error) begin
                  error_flag_in = 1'b1;
               end else if (!error_flag_ff) begin
                  if (count_full) begin
                     error_flag_in = 1'b1;
                  end else begin
                     if (count_ff == '0) begin
                        address_in = req_chan.data_byte;
                     end
                     crc_in   = crc_folded;
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && req_chan.func == FUNC_END) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         error_flag_ff <= 1'b0;
         crc_ff        <= CRC_INIT;
         address_ff    <= 8'h00;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         error_flag_ff <= error_flag_in;
         crc_ff        <= crc_in;
         address_ff    <= address_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload only loads on a frame-end beat
   always_ff @(posedge clock) begin
      if (req_fire && req_chan.func == FUNC_END) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.error_reason  = rsp_ff.error_reason;
   assign rsp_chan.slave_address = rsp_ff.slave_address;
   assign rsp_chan.pdu_length    = rsp_ff.pdu_length;

`include "rtu_frame_receive_checker_top_macros.svh"

   // byte count is bounded by the frame limit
   `RTUFRC_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CW'(FRAME_MAX))
   // a frame-end beat always leaves a response pending
   `RTUFRC_ASSERT_NEXT(a_end_gives_rsp, req_fire && req_chan.func == FUNC_END, rsp_valid_ff)
   // bytes after an error do not advance the count
   `RTUFRC_ASSERT_NEXT(a_err_holds_count, req_fire && req_chan.func == FUNC_BYTE && error_flag_ff, $stable(count_ff))
   // failed frames report no address and no length
   `RTUFRC_ASSERT_IMPL(a_fail_zero, rsp_valid_ff && rsp_ff.status, rsp_ff.slave_address == 8'h00 && rsp_ff.pdu_length == 8'h00 && rsp_ff.error_reason != REASON_NONE)

endmodule
